[rtl/core/fvu_pkg.sv]
`default_nettype none
package fvu_pkg;

   localparam int COORD_BITS   = 24;
   localparam int MAX_AGENTS   = 64;
   localparam int AIDX_BITS    = $clog2(MAX_AGENTS);
   localparam int CNT_BITS     = AIDX_BITS + 1;
   localparam int SUM_BITS     = COORD_BITS + AIDX_BITS + 2;
   localparam int VEL_BITS     = COORD_BITS + 8;
   localparam int MUL_A_BITS   = VEL_BITS + 2;
   localparam int GAIN_BITS    = 18;
   localparam int PROD_BITS    = MUL_A_BITS + GAIN_BITS;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int DIST2_BITS   = 2 * DIFF_BITS;
   localparam int RANGE_BITS   = 23;
   localparam int RADIUS2_BITS = 2 * RANGE_BITS;
   localparam int ENTRY_BITS   = 2 * COORD_BITS;
   localparam int GAIN_SHIFT   = 20;
   localparam int CSR_IDX_BITS = 2;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
   localparam int REM_BITS     = CNT_BITS + 1;

   localparam logic signed [GAIN_BITS-1:0] GAIN_SEP   = 18'sd52429;
   localparam logic signed [GAIN_BITS-1:0] GAIN_ALIGN = 18'sd52429;
   localparam logic signed [GAIN_BITS-1:0] GAIN_COH   = 18'sd5243;
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
      PROD_BITS'(64'sd1 <<< (GAIN_SHIFT - 1));
   localparam logic signed [VEL_BITS-1:0] VEL_MAX =
      VEL_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [VEL_BITS-1:0] VEL_MIN =
      VEL_BITS'(-(64'sd1 <<< (COORD_BITS - 1)));

   localparam logic [CSR_IDX_BITS-1:0] REG_ACTIVE_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_VIEW_RADIUS  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SEP_RADIUS   = 2'd2;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_SELF, S_DIFF, S_SQ, S_ACC, S_SEP_M, S_SEP_A,
      S_DIV, S_ALN_M, S_ALN_A, S_COH_M, S_COH_A, S_SAT
   } state_type;

   typedef struct packed {
      logic                       start;
      logic signed [SUM_BITS-1:0] dividend;
      logic [CNT_BITS-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                       busy;
      logic                       done;
      logic signed [SUM_BITS-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [VEL_BITS-1:0] round_gain(
      input logic signed [PROD_BITS-1:0] p);
      logic signed [PROD_BITS-1:0] t;
      t = p + ROUND_HALF;
      return VEL_BITS'(t >>> GAIN_SHIFT);
   endfunction

endpackage
`default_nettype wire

[rtl/core/fvu_ram.sv]
`default_nettype none
module fvu_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

[rtl/core/fvu_div.sv]
`default_nettype none
module fvu_div import fvu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]     mag_ff, mag_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   logic [CNT_BITS-1:0]     den_ff, den_in;
   logic                    neg_ff, neg_in;
   logic [REM_BITS-1:0]     rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff[REM_BITS-2:0], mag_ff[SUM_BITS-1]};
      if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            mag_in = {mag_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            mag_in = {mag_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(SUM_BITS);
         neg_in  = req.dividend[SUM_BITS-1];
         mag_in  = req.dividend[SUM_BITS-1] ? SUM_BITS'(-req.dividend)
                                            : SUM_BITS'(req.dividend);
         rem_in  = '0;
         den_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp = {busy_ff, done_ff, neg_ff ? -signed'(mag_ff) : signed'(mag_ff)};

endmodule
`default_nettype wire

[rtl/core/flocking_velocity_update_top.sv]
// Flocking velocity update.
// req_ carries transactions: tuser[0] = 0 writes an agent entry (position and
// velocity), tuser[0] = 1 updates the named agent's velocity from the flock.
// A write gives no result. An update reads the agent, walks the first
// active_count entries (at most 64): read, difference, squares, compare and
// sum through the table RAM port. It then applies the separation gain and,
// when neighbours were found, runs four serial divisions through one shared
// divider and applies the alignment and cohesion gains, each gain a multiply
// then a round.
// The result goes to a registered rsp_ stage; the core takes the next
// transaction while it waits, and stalls only when a second result is ready
// before the first has been taken.
// csr_ writes the active count (0), neighbour radius (1) and separation
// radius (2); csr_ready is always high. Write only while idle.
// Reset is synchronous: registers return to 64, 19200 and 5120; the flock
// table is undefined until written.
`default_nettype none
module flocking_velocity_update_top import fvu_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // agent_index, pos_x, pos_y, vel_x, vel_y, zero pad
   input  wire logic [103:0]            req_tdata,
   // func
   input  wire logic [0:0]              req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // updated_index, new_vel_x, new_vel_y, neighbour_count, zero pad
   output logic [63:0]                  rsp_tdata,
   // saturated
   output logic [0:0]                   rsp_tuser,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [RANGE_BITS-1:0]   csr_data
);

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0]   active_count_ff;
   logic [RANGE_BITS-1:0] view_radius_ff, sep_radius_ff;

   logic [AIDX_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0]  n_ff, n_in, j_ff, j_in, cnt_ff, cnt_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [VEL_BITS-1:0]   vx_ff, vx_in, vy_ff, vy_in;
   logic signed [DIFF_BITS-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [COORD_BITS-1:0] ovx_ff, ovx_in, ovy_ff, ovy_in;
   logic signed [COORD_BITS-1:0] opx_ff, opx_in, opy_ff, opy_in;
   logic [DIST2_BITS-1:0]        d2_ff, d2_in;
   logic [RADIUS2_BITS-1:0]      rmin2_ff, rmin2_in, rvis2_ff, rvis2_in;
   logic signed [SUM_BITS-1:0]   sepx_ff, sepx_in, sepy_ff, sepy_in;
   logic signed [SUM_BITS-1:0]   svx_ff, svx_in, svy_ff, svy_in;
   logic signed [SUM_BITS-1:0]   spx_ff, spx_in, spy_ff, spy_in;
   logic signed [SUM_BITS-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic signed [SUM_BITS-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0]                   sel_ff, sel_in, pick;
   logic signed [PROD_BITS-1:0]  prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [MUL_A_BITS-1:0] mul_ax, mul_ay;
   logic signed [GAIN_BITS-1:0]  mul_g;
   logic signed [DIST2_BITS-1:0] sqx, sqy;
   logic                         rsp_load;
   logic                         rsp_valid_ff;
   logic [63:0]                  rsp_data_ff;
   logic                         rsp_sat_ff;
   logic signed [VEL_BITS-1:0]   satx, saty;
   logic                         sat_flag;

   logic                   ram_pos_we, ram_vel_we;
   logic [AIDX_BITS-1:0]   ram_waddr, ram_raddr;
   logic [ENTRY_BITS-1:0]  ram_pos_wdata, ram_vel_wdata;
   logic [ENTRY_BITS-1:0]  pos_rdata, vel_rdata;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic                       div_start;
   logic signed [SUM_BITS-1:0] div_dividend;

   logic                         req_func;
   logic [AIDX_BITS-1:0]         req_idx;
   logic signed [COORD_BITS-1:0] rd_px, rd_py, rd_vx, rd_vy;

   assign req_func = req_tuser[0];
   assign req_idx  = req_tdata[5:0];
   assign rd_px    = signed'(pos_rdata[COORD_BITS-1:0]);
   assign rd_py    = signed'(pos_rdata[ENTRY_BITS-1:COORD_BITS]);
   assign rd_vx    = signed'(vel_rdata[COORD_BITS-1:0]);
   assign rd_vy    = signed'(vel_rdata[ENTRY_BITS-1:COORD_BITS]);

   fvu_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_AGENTS)) u_pos_ram (
      .clock (clock),
      .we    (ram_pos_we),
      .waddr (ram_waddr),
      .wdata (ram_pos_wdata),
      .raddr (ram_raddr),
      .rdata (pos_rdata)
   );

   fvu_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_AGENTS)) u_vel_ram (
      .clock (clock),
      .we    (ram_vel_we),
      .waddr (ram_waddr),
      .wdata (ram_vel_wdata),
      .raddr (ram_raddr),
      .rdata (vel_rdata)
   );

   fvu_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign sqx      = dx_ff * dx_ff;
   assign sqy      = dy_ff * dy_ff;
   assign rmin2_in = sep_radius_ff * sep_radius_ff;
   assign rvis2_in = view_radius_ff * view_radius_ff;
   assign prodx_in = mul_ax * mul_g;
   assign prody_in = mul_ay * mul_g;

   always_comb begin
      satx     = vx_ff;
      saty     = vy_ff;
      sat_flag = 1'b0;
      if (vx_ff > VEL_MAX) begin
         satx = VEL_MAX; sat_flag = 1'b1;
      end else if (vx_ff < VEL_MIN) begin
         satx = VEL_MIN; sat_flag = 1'b1;
      end
      if (vy_ff > VEL_MAX) begin
         saty = VEL_MAX; sat_flag = 1'b1;
      end else if (vy_ff < VEL_MIN) begin
         saty = VEL_MIN; sat_flag = 1'b1;
      end
   end

   always_comb begin
      case (pick)
         2'd0:    div_dividend = svx_ff;
         2'd1:    div_dividend = svy_ff;
         2'd2:    div_dividend = spx_ff;
         default: div_dividend = spy_ff;
      endcase
   end
   assign div_req = {div_start, div_dividend, cnt_ff};

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; n_in = n_ff; j_in = j_ff; cnt_in = cnt_ff;
      px_in = px_ff; py_in = py_ff; vx_in = vx_ff; vy_in = vy_ff;
      dx_in = dx_ff; dy_in = dy_ff; d2_in = d2_ff;
      ovx_in = ovx_ff; ovy_in = ovy_ff; opx_in = opx_ff; opy_in = opy_ff;
      sepx_in = sepx_ff; sepy_in = sepy_ff; svx_in = svx_ff; svy_in = svy_ff;
      spx_in = spx_ff; spy_in = spy_ff;
      ax_in = ax_ff; ay_in = ay_ff; cx_in = cx_ff; cy_in = cy_ff;
      sel_in = sel_ff; pick = sel_ff;
      div_start = 1'b0;
      mul_ax = MUL_A_BITS'(sepx_ff);
      mul_ay = MUL_A_BITS'(sepy_ff);
      mul_g  = GAIN_SEP;
      req_tready = 1'b0;
      rsp_load = 1'b0;
      ram_pos_we = 1'b0;
      ram_vel_we = 1'b0;
      ram_waddr = idx_ff;
      ram_raddr = j_ff[AIDX_BITS-1:0];
      ram_pos_wdata = req_tdata[53:6];
      ram_vel_wdata = req_tdata[101:54];

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            ram_raddr  = req_idx;
            ram_waddr  = req_idx;
            if (req_tvalid) begin
               if (req_func == FUNC_WRITE) begin
                  ram_pos_we = 1'b1;
                  ram_vel_we = 1'b1;
               end else begin
                  idx_in   = req_idx;
                  n_in     = (active_count_ff > CNT_BITS'(MAX_AGENTS))
                             ? CNT_BITS'(MAX_AGENTS) : active_count_ff;
                  state_in = S_SELF;
               end
            end
         end
         S_SELF: begin
            px_in = rd_px;
            py_in = rd_py;
            vx_in = VEL_BITS'(rd_vx);
            vy_in = VEL_BITS'(rd_vy);
            j_in = '0; cnt_in = '0;
            sepx_in = '0; sepy_in = '0; svx_in = '0; svy_in = '0;
            spx_in = '0; spy_in = '0;
            ram_raddr = '0;
            state_in = (n_ff == '0) ? S_SEP_M : S_DIFF;
         end
         S_DIFF: begin
            dx_in  = DIFF_BITS'(px_ff) - DIFF_BITS'(rd_px);
            dy_in  = DIFF_BITS'(py_ff) - DIFF_BITS'(rd_py);
            opx_in = rd_px; opy_in = rd_py;
            ovx_in = rd_vx; ovy_in = rd_vy;
            state_in = S_SQ;
         end
         S_SQ: begin
            d2_in    = unsigned'(sqx) + unsigned'(sqy);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (j_ff != {1'b0, idx_ff}) begin
               if (d2_ff <= DIST2_BITS'(rmin2_ff)) begin
                  sepx_in = sepx_ff + SUM_BITS'(dx_ff);
                  sepy_in = sepy_ff + SUM_BITS'(dy_ff);
               end
               if (d2_ff <= DIST2_BITS'(rvis2_ff)) begin
                  svx_in = svx_ff + SUM_BITS'(ovx_ff);
                  svy_in = svy_ff + SUM_BITS'(ovy_ff);
                  spx_in = spx_ff + SUM_BITS'(opx_ff);
                  spy_in = spy_ff + SUM_BITS'(opy_ff);
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            j_in      = j_ff + 1'b1;
            ram_raddr = j_in[AIDX_BITS-1:0];
            state_in  = (j_in == n_ff) ? S_SEP_M : S_DIFF;
         end
         S_SEP_M: state_in = S_SEP_A;
         S_SEP_A: begin
            vx_in = vx_ff + round_gain(prodx_ff);
            vy_in = vy_ff + round_gain(prody_ff);
            if (cnt_ff == '0) begin
               state_in = S_SAT;
            end else begin
               pick      = 2'd0;
               sel_in    = 2'd0;
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               case (sel_ff)
                  2'd0:    ax_in = div_rsp.quotient;
                  2'd1:    ay_in = div_rsp.quotient;
                  2'd2:    cx_in = div_rsp.quotient;
                  default: cy_in = div_rsp.quotient;
               endcase
               if (sel_ff == 2'd3) begin
                  state_in = S_ALN_M;
               end else begin
                  pick      = sel_ff + 1'b1;
                  sel_in    = pick;
                  div_start = 1'b1;
               end
            end
         end
         S_ALN_M: begin
            mul_ax   = MUL_A_BITS'(ax_ff) - MUL_A_BITS'(vx_ff);
            mul_ay   = MUL_A_BITS'(ay_ff) - MUL_A_BITS'(vy_ff);
            mul_g    = GAIN_ALIGN;
            state_in = S_ALN_A;
         end
         S_ALN_A: begin
            vx_in    = vx_ff + round_gain(prodx_ff);
            vy_in    = vy_ff + round_gain(prody_ff);
            state_in = S_COH_M;
         end
         S_COH_M: begin
            mul_ax   = MUL_A_BITS'(cx_ff) - MUL_A_BITS'(px_ff);
            mul_ay   = MUL_A_BITS'(cy_ff) - MUL_A_BITS'(py_ff);
            mul_g    = GAIN_COH;
            state_in = S_COH_A;
         end
         S_COH_A: begin
            vx_in    = vx_ff + round_gain(prodx_ff);
            vy_in    = vy_ff + round_gain(prody_ff);
            state_in = S_SAT;
         end
         S_SAT: begin
            ram_vel_wdata = {saty[COORD_BITS-1:0], satx[COORD_BITS-1:0]};
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load   = 1'b1;
               ram_vel_we = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         active_count_ff <= CNT_BITS'(64);
         view_radius_ff  <= RANGE_BITS'(19200);
         sep_radius_ff   <= RANGE_BITS'(5120);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               REG_ACTIVE_COUNT: active_count_ff <= csr_data[CNT_BITS-1:0];
               REG_VIEW_RADIUS:  view_radius_ff  <= csr_data;
               REG_SEP_RADIUS:   sep_radius_ff   <= csr_data;
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= {4'b0, cnt_ff[AIDX_BITS-1:0], saty[COORD_BITS-1:0],
                         satx[COORD_BITS-1:0], idx_ff};
         rsp_sat_ff  <= sat_flag;
      end
      idx_ff <= idx_in; n_ff <= n_in; j_ff <= j_in; cnt_ff <= cnt_in;
      px_ff <= px_in; py_ff <= py_in; vx_ff <= vx_in; vy_ff <= vy_in;
      dx_ff <= dx_in; dy_ff <= dy_in; d2_ff <= d2_in;
      ovx_ff <= ovx_in; ovy_ff <= ovy_in; opx_ff <= opx_in; opy_ff <= opy_in;
      rmin2_ff <= rmin2_in; rvis2_ff <= rvis2_in;
      sepx_ff <= sepx_in; sepy_ff <= sepy_in; svx_ff <= svx_in; svy_ff <= svy_in;
      spx_ff <= spx_in; spy_ff <= spy_in;
      ax_ff <= ax_in; ay_ff <= ay_in; cx_ff <= cx_in; cy_ff <= cy_in;
      sel_ff <= sel_in;
      prodx_ff <= prodx_in; prody_ff <= prody_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SAT && state_in == S_IDLE) |=> rsp_tvalid)
      else $error("result not presented after update");
   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> state_ff == S_DIV)
      else $error("divider busy outside division phase");
   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC |-> j_ff < n_ff)
      else $error("walk index beyond active entries");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SAT |-> cnt_ff < CNT_BITS'(MAX_AGENTS))
      else $error("neighbour count out of range");

endmodule
`default_nettype wire

[tb/tb_flocking_velocity_update_top.sv]
`default_nettype none
module tb_flocking_velocity_update_top import fvu_pkg::*; ();

   typedef struct {
      logic [5:0]         index;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic [5:0]         neighbours;
      logic               saturated;
   } velocity_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [103:0]            req_tdata;
   logic [0:0]              req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [63:0]             rsp_tdata;
   logic [0:0]              rsp_tuser;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [RANGE_BITS-1:0]   csr_data;

   // flock table and registers as the block should hold them
   longint flock_px [MAX_AGENTS];
   longint flock_py [MAX_AGENTS];
   longint flock_vx [MAX_AGENTS];
   longint flock_vy [MAX_AGENTS];
   longint active_count, view_radius, sep_radius;

   velocity_result_type pending_velocities[$];
   int  failures;
   int  hold_cycles;
   int  items_sent;

   flocking_velocity_update_top u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30000000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint round_gain_q(input longint x);
      return (x + (64'sd1 <<< 19)) >>> 20;
   endfunction

   function automatic bit in_radius(input longint dx, input longint dy, input longint r);
      longint adx, ady;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      if (adx >= 64'sd16777216 || ady >= 64'sd16777216) return 1'b0;
      return dx * dx + dy * dy <= r * r;
   endfunction

   function automatic longint clamp_vel(input longint v, inout bit flag);
      if (v > 64'sd8388607) begin
         flag = 1'b1;
         return 64'sd8388607;
      end
      if (v < -64'sd8388608) begin
         flag = 1'b1;
         return -64'sd8388608;
      end
      return v;
   endfunction

   function automatic void predict_velocity(input int idx);
      velocity_result_type r;
      longint n, px, py, vx, vy, dx, dy;
      longint sepx, sepy, svx, svy, spx, spy, cnt;
      bit sat;
      n = active_count > MAX_AGENTS ? MAX_AGENTS : active_count;
      px = flock_px[idx]; py = flock_py[idx];
      vx = flock_vx[idx]; vy = flock_vy[idx];
      sepx = 0; sepy = 0; svx = 0; svy = 0; spx = 0; spy = 0; cnt = 0;
      sat = 1'b0;
      for (int j = 0; j < n; j++) begin
         if (j == idx) continue;
         dx = px - flock_px[j];
         dy = py - flock_py[j];
         if (in_radius(dx, dy, sep_radius)) begin
            sepx += dx;
            sepy += dy;
         end
         if (in_radius(dx, dy, view_radius)) begin
            svx += flock_vx[j];
            svy += flock_vy[j];
            spx += flock_px[j];
            spy += flock_py[j];
            cnt++;
         end
      end
      vx += round_gain_q(sepx * 52429);
      vy += round_gain_q(sepy * 52429);
      if (cnt > 0) begin
         vx += round_gain_q((svx / cnt - vx) * 52429);
         vy += round_gain_q((svy / cnt - vy) * 52429);
         vx += round_gain_q((spx / cnt - px) * 5243);
         vy += round_gain_q((spy / cnt - py) * 5243);
      end
      vx = clamp_vel(vx, sat);
      vy = clamp_vel(vy, sat);
      flock_vx[idx] = vx;
      flock_vy[idx] = vy;
      r.index = idx[5:0];
      r.vel_x = vx[23:0];
      r.vel_y = vy[23:0];
      r.neighbours = cnt > 63 ? 6'd63 : cnt[5:0];
      r.saturated = sat;
      pending_velocities = {pending_velocities, r};
   endfunction

   task automatic send_item(input logic func, input logic [5:0] idx,
                            input logic signed [23:0] px, input logic signed [23:0] py,
                            input logic signed [23:0] vx, input logic signed [23:0] vy);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, vy, vx, py, px, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (func == FUNC_WRITE) begin
         flock_px[idx] = px; flock_py[idx] = py;
         flock_vx[idx] = vx; flock_vy[idx] = vy;
      end else begin
         predict_velocity(idx);
      end
   endtask

   task automatic write_agent(input int idx, input longint px, input longint py,
                              input longint vx, input longint vy);
      send_item(FUNC_WRITE, idx[5:0], px[23:0], py[23:0], vx[23:0], vy[23:0]);
   endtask

   task automatic update_agent(input int idx);
      send_item(FUNC_UPDATE, idx[5:0], 24'($urandom), 24'($urandom),
                24'($urandom), 24'($urandom));
   endtask

   task automatic wait_idle();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_velocities.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input longint value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[22:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ACTIVE_COUNT: active_count = value & 64'h7F;
         REG_VIEW_RADIUS:  view_radius  = value & 64'h7FFFFF;
         REG_SEP_RADIUS:   sep_radius   = value & 64'h7FFFFF;
         default: ;
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic longint near(input longint centre, input int spread);
      return centre + $signed($urandom_range(0, 2 * spread)) - spread;
   endfunction

   function automatic longint any_coord();
      return longint'($signed(24'($urandom)));
   endfunction

   task automatic test_table_fill();
      for (int i = 0; i < MAX_AGENTS; i++)
         write_agent(i, near(0, 20000), near(0, 20000), near(0, 1500), near(0, 1500));
   endtask

   task automatic test_directed();
      // far apart corners, exact max and min values
      write_agent(0, 8388607, 8388607, 8388607, 8388607);
      write_agent(1, -8388608, -8388608, -8388608, -8388608);
      update_agent(0);
      update_agent(1);
      // two agents almost on top of each other: separation
      write_agent(2, 100, -100, 0, 0);
      write_agent(3, 300, 200, 256, -256);
      update_agent(2);
      update_agent(3);
      wait_idle();
      write_reg(REG_ACTIVE_COUNT, 0);
      update_agent(5);
      wait_idle();
      write_reg(REG_ACTIVE_COUNT, 1);
      update_agent(0);
      update_agent(63);
      wait_idle();
      write_reg(REG_ACTIVE_COUNT, 4);
      update_agent(63);
      wait_idle();
      write_reg(REG_ACTIVE_COUNT, 127);
      write_reg(REG_VIEW_RADIUS, 0);
      write_reg(REG_SEP_RADIUS, 8388607);
      update_agent(10);
      update_agent(2);
      wait_idle();
      write_reg(REG_VIEW_RADIUS, 8388607);
      write_reg(3, 5);
      update_agent(11);
      write_agent(4, 8388607, 8388607, 8388000, 8388000);
      update_agent(4);
      wait_idle();
   endtask

   task automatic test_backpressure();
      hold_cycles = 3000;
      for (int i = 0; i < 6; i++) update_agent($urandom_range(0, 63));
      wait_idle();
   endtask

   task automatic test_random_phase(input int items);
      longint cx, cy;
      int spread;
      cx = any_coord() / 4;
      cy = any_coord() / 4;
      spread = $urandom_range(500, 40000);
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 99) < 55)
            update_agent($urandom_range(0, 63));
         else if ($urandom_range(0, 9) == 0)
            write_agent($urandom_range(0, 63), any_coord(), any_coord(),
                        any_coord(), any_coord());
         else
            write_agent($urandom_range(0, 63), near(cx, spread), near(cy, spread),
                        near(0, 3000), near(0, 3000));
      end
      wait_idle();
   endtask

   task automatic test_random();
      longint counts[4] = '{64, 127, 1, 32};
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_ACTIVE_COUNT, p < 4 ? counts[p] : $urandom_range(0, 127));
         write_reg(REG_VIEW_RADIUS, p == 1 ? 8388607 : $urandom_range(2000, 60000));
         write_reg(REG_SEP_RADIUS, p == 2 ? 0 : $urandom_range(500, 15000));
         test_random_phase(200);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      failures   = 0;
      hold_cycles = 0;
      items_sent = 0;
      active_count = 64;
      view_radius  = 19200;
      sep_radius   = 5120;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_table_fill();
      test_directed();
      test_backpressure();
      test_random();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_velocities.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // receiver: own stall pattern, plus the long hold-off
   initial begin
      int mode;
      int left;
      rsp_tready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(5, 200);
         end
         left--;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (mode == 0)
            rsp_tready <= 1'b1;
         else if (mode == 1)
            rsp_tready <= ($urandom_range(0, 1) == 1);
         else
            rsp_tready <= ($urandom_range(0, 7) == 0);
      end
   end

   always @(posedge clock) begin
      velocity_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_velocities.size() == 0) begin
            $error("unexpected transaction: %h", rsp_tdata);
            failures++;
         end else begin
            e = pending_velocities.pop_front();
            if (rsp_tdata[5:0] !== e.index) begin
               $error("updated_index exp %0d got %0d", e.index, rsp_tdata[5:0]);
               failures++;
            end
            if (rsp_tdata[29:6] !== e.vel_x) begin
               $error("new_vel_x exp %h got %h", e.vel_x, rsp_tdata[29:6]);
               failures++;
            end
            if (rsp_tdata[53:30] !== e.vel_y) begin
               $error("new_vel_y exp %h got %h", e.vel_y, rsp_tdata[53:30]);
               failures++;
            end
            if (rsp_tdata[59:54] !== e.neighbours) begin
               $error("neighbour_count exp %0d got %0d", e.neighbours, rsp_tdata[59:54]);
               failures++;
            end
            if (rsp_tuser[0] !== e.saturated) begin
               $error("saturated exp %0d got %0d", e.saturated, rsp_tuser[0]);
               failures++;
            end
         end
      end
   end

endmodule
`default_nettype wire
